[rtl/gost_block_cipher_defines.svh]
// Assertion macros used by the GOST round cell RTL.
`ifndef GOST_BLOCK_CIPHER_DEFINES_SVH
`define GOST_BLOCK_CIPHER_DEFINES_SVH

// same-cycle implication
`define GOST_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gost assertion failed");

// next-cycle implication
`define GOST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gost assertion failed");

`endif

[rtl/gost_pkg.sv]
// Package: types, S-box, round function and key schedule of the GOST cipher.
`default_nettype none

package gost_pkg;

  localparam int unsigned ROUNDS = 32;
  localparam int unsigned KEY_WORDS = 8;
  localparam int unsigned CFG_REGS = 4;
  localparam int unsigned ROT_L = 11;
  localparam int unsigned ROT_R = 21;

  typedef struct packed {
    logic        kind;
    logic [31:0] lo;
    logic [31:0] hi;
  } gost_blk_t;

  localparam logic [3:0] SBOX [8][16] = '{
    '{4'd4, 4'd10, 4'd9, 4'd2, 4'd13, 4'd8, 4'd0, 4'd14,
      4'd6, 4'd11, 4'd1, 4'd12, 4'd7, 4'd15, 4'd5, 4'd3},
    '{4'd14, 4'd11, 4'd4, 4'd12, 4'd6, 4'd13, 4'd15, 4'd10,
      4'd2, 4'd3, 4'd8, 4'd1, 4'd0, 4'd7, 4'd5, 4'd9},
    '{4'd5, 4'd8, 4'd1, 4'd13, 4'd10, 4'd3, 4'd4, 4'd2,
      4'd14, 4'd15, 4'd12, 4'd7, 4'd6, 4'd0, 4'd9, 4'd11},
    '{4'd7, 4'd13, 4'd10, 4'd1, 4'd0, 4'd8, 4'd9, 4'd15,
      4'd14, 4'd4, 4'd6, 4'd12, 4'd11, 4'd2, 4'd5, 4'd3},
    '{4'd6, 4'd12, 4'd7, 4'd1, 4'd5, 4'd15, 4'd13, 4'd8,
      4'd4, 4'd10, 4'd9, 4'd14, 4'd0, 4'd3, 4'd11, 4'd2},
    '{4'd4, 4'd11, 4'd10, 4'd0, 4'd7, 4'd2, 4'd1, 4'd13,
      4'd3, 4'd6, 4'd8, 4'd5, 4'd9, 4'd12, 4'd15, 4'd14},
    '{4'd13, 4'd11, 4'd4, 4'd1, 4'd3, 4'd15, 4'd5, 4'd9,
      4'd0, 4'd10, 4'd14, 4'd7, 4'd6, 4'd8, 4'd2, 4'd12},
    '{4'd1, 4'd15, 4'd13, 4'd0, 4'd5, 4'd7, 4'd10, 4'd4,
      4'd9, 4'd2, 4'd3, 4'd14, 4'd6, 4'd11, 4'd8, 4'd12}
  };

  function automatic logic [31:0] round_fn(logic [31:0] half, logic [31:0] key);
    logic [31:0] s;
    logic [31:0] t;
    s = half + key;
    for (int p = 0; p < 8; p++) begin
      t[4*p +: 4] = SBOX[p][s[4*p +: 4]];
    end
    return (t << ROT_L) | (t >> ROT_R);
  endfunction

  // key word used in round r; forward passes take 0..7, reverse 7..0
  function automatic logic [2:0] key_index(int unsigned r, logic dec);
    logic [2:0] pos;
    logic [1:0] pass;
    logic       fwd;
    pos  = 3'(r % 8);
    pass = 2'((r / 8) % 4);
    fwd  = dec ? (pass == 2'd0) : (pass != 2'd3);
    return fwd ? pos : (3'd7 - pos);
  endfunction

endpackage

`default_nettype wire

[rtl/gost_round_cell.sv]
// One Feistel round cell with its own stage register and ready chain link.
`default_nettype none

module gost_round_cell (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  input  wire gost_pkg::gost_blk_t data_i,
  output logic                    ready_o,
  input  wire logic [31:0]        key_enc_i,
  input  wire logic [31:0]        key_dec_i,
  output logic                    valid_o,
  output gost_pkg::gost_blk_t     data_o,
  input  wire logic               ready_i
);

  `include "gost_block_cipher_defines.svh"

  logic                valid_q, valid_d;
  gost_pkg::gost_blk_t data_q, data_d;
  logic [31:0]         key;

  assign ready_o = !valid_q || ready_i;
  assign key     = data_i.kind ? key_dec_i : key_enc_i;

  always_comb begin
    data_d.kind = data_i.kind;
    data_d.hi   = data_i.lo;
    data_d.lo   = gost_pkg::round_fn(data_i.lo, key) ^ data_i.hi;
    valid_d     = ready_o ? valid_i : valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

  `GOST_ASSERT_NEXT(a_hold, valid_q && !ready_i, valid_q && $stable(data_q))
  `GOST_ASSERT_NEXT(a_load, valid_i && ready_o, valid_q)
  `GOST_ASSERT_NEXT(a_drain, valid_q && ready_i && !valid_i, !valid_q)

endmodule

`default_nettype wire

[rtl/gost_block_cipher.sv]
// GOST 28147-89 block cipher: key registers and a chain of 32 round cells.
//
//   channel  dir  handshake                fields
//   in       in   in_valid_i / in_stall_o   kind_i, block_lo_i, block_hi_i
//   out      out  out_valid_o / out_stall_i result_lo_o, result_hi_o
//   cfg      in   cfg_we_i                  cfg_idx_i, cfg_data_i
//
// One item per cycle sustained while out_stall_i is low; one register stage per round cell.
// Each cell holds one item; a stalled cell holds while empty cells
// upstream keep filling, so bubbles collapse under output stalls.
// Reset clears the cell valid bits and the key registers to zero.
`default_nettype none

module gost_block_cipher (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [63:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        kind_i,
  input  wire logic [31:0] block_lo_i,
  input  wire logic [31:0] block_hi_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      result_lo_o,
  output logic [31:0]      result_hi_o
);

  logic [63:0]         key_q [gost_pkg::CFG_REGS];
  logic [31:0]         key_w [gost_pkg::KEY_WORDS];
  logic                valid [gost_pkg::ROUNDS+1];
  logic                ready [gost_pkg::ROUNDS+1];
  gost_pkg::gost_blk_t data  [gost_pkg::ROUNDS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < gost_pkg::CFG_REGS; i++) begin
        key_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      key_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  always_comb begin
    for (int i = 0; i < gost_pkg::CFG_REGS; i++) begin
      key_w[2*i]   = key_q[i][31:0];
      key_w[2*i+1] = key_q[i][63:32];
    end
  end

  assign valid[0]     = in_valid_i;
  assign data[0].kind = kind_i;
  assign data[0].lo   = block_lo_i;
  assign data[0].hi   = block_hi_i;
  assign in_stall_o   = !ready[0];

  for (genvar r = 0; r < gost_pkg::ROUNDS; r++) begin : g_cell
    localparam logic [2:0] EncIdx = gost_pkg::key_index(r, 1'b0);
    localparam logic [2:0] DecIdx = gost_pkg::key_index(r, 1'b1);

    gost_round_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .valid_i   (valid[r]),
      .data_i    (data[r]),
      .ready_o   (ready[r]),
      .key_enc_i (key_w[EncIdx]),
      .key_dec_i (key_w[DecIdx]),
      .valid_o   (valid[r+1]),
      .data_o    (data[r+1]),
      .ready_i   (ready[r+1])
    );
  end

  assign ready[gost_pkg::ROUNDS] = !out_stall_i;
  assign out_valid_o = valid[gost_pkg::ROUNDS];
  assign result_lo_o = data[gost_pkg::ROUNDS].hi;
  assign result_hi_o = data[gost_pkg::ROUNDS].lo;

endmodule

`default_nettype wire
